/* design/tlf_pkg.sv */
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants of the text line folder
// Character codes, register indexes, the command word from the front end to
// the back end, and the result word from the back end to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tlf_pkg;

    localparam int BYTE_W     = 8;
    localparam int FOLD_W     = 6;
    localparam int TAB_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Largest tab advance that the tab width register can ask for.
    localparam int TAB_MAX = 15;

    localparam logic [BYTE_W-1:0] CH_BLANK   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;

    localparam logic [FOLD_W-1:0] FOLD_RESET = 6'd10;
    localparam logic [TAB_W-1:0]  TAB_RESET  = 4'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_COLUMN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH   = 1'd1;

    typedef logic [1:0] kind_t;

    localparam kind_t K_CHAR    = 2'd0;
    localparam kind_t K_NEWLINE = 2'd1;
    localparam kind_t K_FLUSH   = 2'd2;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] ch;
        logic              is_blank;
        logic              is_tab;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } res_t;

    function automatic logic is_blank_char(input logic [BYTE_W-1:0] c);
        return (c == CH_BLANK) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

/* design/text_line_folder.sv */
// ----------------------------------------------------------------------------
// text_line_folder: word wrap of a byte stream at a set column
//
//   Channel   Direction  Handshake          Payload
//   input     in         push / full        in_byte, end_of_text
//   result    out        empty / pop        out_byte, last
//   config    in         cfg_we             cfg_index, cfg_wdata
//
// A character that does not fold passes the check and append states; bytes and
// newlines go out one a cycle while the result queue has room. A fold at a
// blank adds shift, scan and recheck states to rebuild column and break point.
// After a tab width write, the next character first rebuilds the tab phase.
// Reset clears the line. Two-entry queues on both sides let input and output
// stall independently; a full result queue holds the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_folder #(
    parameter int MAX_COLUMNS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [tlf_pkg::BYTE_W-1:0]     in_byte,
    input  wire logic                           end_of_text,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [tlf_pkg::BYTE_W-1:0]          out_byte,
    output logic                                last,
    input  wire logic                           cfg_we,
    input  wire logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tlf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tlf_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t res;
    logic res_push;
    logic res_full;

    tlf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    tlf_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    tlf_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

`default_nettype wire

/* design/tlf_front.sv */
// ----------------------------------------------------------------------------
// tlf_front: request intake and classification
// Accepts input requests, sorts them into flush, newline and character
// commands, and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [tlf_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                      end_of_text,
    output logic                           cmd_valid,
    output tlf_pkg::cmd_t                  cmd,
    input  wire logic                      cmd_pop
);
    import tlf_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       q_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       new_cmd;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        new_cmd.ch       = in_byte;
        new_cmd.is_tab   = (in_byte == CH_TAB);
        new_cmd.is_blank = is_blank_char(in_byte);
        if (end_of_text)
        begin
            new_cmd.kind = K_FLUSH;
        end
        else if (in_byte == CH_NEWLINE)
        begin
            new_cmd.kind = K_NEWLINE;
        end
        else
        begin
            new_cmd.kind = K_CHAR;
        end
    end

    assign full      = (count_reg == 2'(DEPTH));
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/tlf_outq.sv */
// ----------------------------------------------------------------------------
// tlf_outq: result queue
// Two-entry queue between the back end and the result port, so that the
// back end keeps working while a finished result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_outq (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      res_push,
    input  wire tlf_pkg::res_t             res,
    output logic                           res_full,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [tlf_pkg::BYTE_W-1:0]     out_byte,
    output logic                           last
);
    import tlf_pkg::*;

    localparam int DEPTH = 2;

    res_t       q_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign res_full = (count_reg == 2'(DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign out_byte = q_reg[rd_ptr_reg].data;
    assign last     = q_reg[rd_ptr_reg].last;
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/tlf_back.sv */
// ----------------------------------------------------------------------------
// tlf_back: line buffer and fold engine
// Keeps the pending line in a circular buffer, tracks column, tab phase and
// break point; folded text goes one byte a cycle while the result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_back #(
    parameter int MAX_COLUMNS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tlf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                         cmd_valid,
    input  wire tlf_pkg::cmd_t                cmd,
    output logic                              cmd_pop,
    output logic                              res_push,
    output tlf_pkg::res_t                     res,
    input  wire logic                         res_full
);
    import tlf_pkg::*;

    localparam int AW   = $clog2(MAX_COLUMNS);
    localparam int CW   = $clog2(MAX_COLUMNS + 1);
    localparam int COLW = $clog2((MAX_COLUMNS + 1) * TAB_MAX + 1);
    localparam int MBW  = $clog2(COLW);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MOD     = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_EMIT    = 4'd3;
    localparam logic [3:0] S_SHIFT   = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_RECHECK = 4'd6;
    localparam logic [3:0] S_NL      = 4'd7;
    localparam logic [3:0] S_APPEND  = 4'd8;

    localparam logic [1:0] E_CLEAR = 2'd0;
    localparam logic [1:0] E_NL    = 2'd1;
    localparam logic [1:0] E_SHIFT = 2'd2;

    localparam logic [1:0] N_CLEAR_IDLE   = 2'd0;
    localparam logic [1:0] N_CLEAR_APPEND = 2'd1;
    localparam logic [1:0] N_APPEND       = 2'd2;
    localparam logic [1:0] N_HARD         = 2'd3;

    typedef struct packed {
        logic [COLW-1:0]  col;
        logic [TAB_W-1:0] rem;
    } colrem_t;

    // Column after one byte; rem is the column modulo the tab width.
    function automatic colrem_t col_step(input logic [COLW-1:0] col,
                                         input logic [TAB_W-1:0] rem,
                                         input logic is_tab,
                                         input logic [TAB_W-1:0] tw);
        colrem_t          r;
        logic [TAB_W-1:0] r1;
        r1 = rem + TAB_W'(1);
        if (is_tab)
        begin
            r.col = col + COLW'(tw - rem);
            r.rem = '0;
        end
        else
        begin
            r.col = col + COLW'(1);
            r.rem = (r1 == tw) ? '0 : r1;
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(MAX_COLUMNS))
        begin
            sum = sum - (CW+1)'(MAX_COLUMNS);
        end
        return AW'(sum);
    endfunction

    logic [BYTE_W-1:0] line_mem [MAX_COLUMNS];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [FOLD_W-1:0] fold_reg;
    logic [TAB_W-1:0]  tab_reg;

    logic [3:0]        state_reg,      state_next;
    cmd_t              cmd_reg,        cmd_next;
    logic [CW-1:0]     fill_reg,       fill_next;
    logic [COLW-1:0]   col_reg,        col_next;
    logic [TAB_W-1:0]  rem_reg,        rem_next;
    logic              stale_reg,      stale_next;
    logic [AW-1:0]     brk_reg,        brk_next;
    logic              prev_blank_reg, prev_blank_next;
    logic [AW-1:0]     head_reg,       head_next;
    logic [AW-1:0]     i_reg,          i_next;
    logic [CW-1:0]     emit_n_reg,     emit_n_next;
    logic              emit_last_reg,  emit_last_next;
    logic [1:0]        emit_then_reg,  emit_then_next;
    logic              nl_last_reg,    nl_last_next;
    logic [1:0]        nl_then_reg,    nl_then_next;
    logic [MBW-1:0]    mod_bit_reg,    mod_bit_next;

    logic [TAB_W-1:0]  tw_eff;
    colrem_t           cur_step;
    colrem_t           scan_step;
    logic              cur_ovf;
    logic              rd_blank;
    logic              i_final;
    logic [CW-1:0]     i_plus1;
    logic [CW-1:0]     rd_off;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              mem_we;
    logic              do_clear;
    logic              second;
    logic [TAB_W:0]    mod_tmp;

    assign tw_eff    = (tab_reg == '0) ? TAB_W'(1) : tab_reg;
    assign cur_step  = col_step(col_reg, rem_reg, cmd_reg.is_tab, tw_eff);
    assign scan_step = col_step(col_reg, rem_reg, (rd_data_reg == CH_TAB), tw_eff);
    assign cur_ovf   = (fill_reg >= CW'(MAX_COLUMNS)) || (cur_step.col > COLW'(fold_reg));
    assign rd_blank  = is_blank_char(rd_data_reg);
    assign i_plus1   = CW'(i_reg) + CW'(1);
    assign rd_addr   = phys(head_reg, rd_off);
    assign wr_addr   = phys(head_reg, fill_reg);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        fill_next       = fill_reg;
        col_next        = col_reg;
        rem_next        = rem_reg;
        stale_next      = stale_reg;
        brk_next        = brk_reg;
        prev_blank_next = prev_blank_reg;
        head_next       = head_reg;
        i_next          = i_reg;
        emit_n_next     = emit_n_reg;
        emit_last_next  = emit_last_reg;
        emit_then_next  = emit_then_reg;
        nl_last_next    = nl_last_reg;
        nl_then_next    = nl_then_reg;
        mod_bit_next    = mod_bit_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res             = '0;
        mem_we          = 1'b0;
        rd_off          = '0;
        do_clear        = 1'b0;
        second          = 1'b0;
        mod_tmp         = '0;
        i_final         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    if ((cmd.kind == K_CHAR) && stale_reg)
                    begin
                        rem_next     = '0;
                        mod_bit_next = MBW'(COLW - 1);
                        state_next   = S_MOD;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            // Restoring remainder, one column bit a cycle, to get the tab
            // phase back after the tab width is rewritten or the column wraps.
            S_MOD:
            begin
                mod_tmp = {rem_reg, col_reg[mod_bit_reg]};
                if (mod_tmp >= {1'b0, tw_eff})
                begin
                    mod_tmp = mod_tmp - {1'b0, tw_eff};
                end
                rem_next = mod_tmp[TAB_W-1:0];
                if (mod_bit_reg == '0)
                begin
                    stale_next = 1'b0;
                    state_next = S_CHECK;
                end
                else
                begin
                    mod_bit_next = mod_bit_reg - MBW'(1);
                end
            end

            S_CHECK:
            begin
                i_next = '0;
                unique case (cmd_reg.kind)
                    K_FLUSH:
                    begin
                        if (fill_reg != '0)
                        begin
                            emit_n_next    = fill_reg;
                            emit_last_next = 1'b1;
                            emit_then_next = E_CLEAR;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            do_clear   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    K_NEWLINE:
                    begin
                        nl_last_next = 1'b1;
                        nl_then_next = N_CLEAR_IDLE;
                        if (fill_reg != '0)
                        begin
                            emit_n_next    = fill_reg;
                            emit_last_next = 1'b0;
                            emit_then_next = E_NL;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_NL;
                        end
                    end
                    default:
                    begin
                        if ((fill_reg != '0) && cur_ovf)
                        begin
                            emit_last_next = 1'b0;
                            state_next     = S_EMIT;
                            if (brk_reg != '0)
                            begin
                                emit_n_next    = CW'(brk_reg);
                                emit_then_next = E_SHIFT;
                            end
                            else
                            begin
                                emit_n_next    = fill_reg;
                                emit_then_next = E_NL;
                                nl_last_next   = 1'b1;
                                nl_then_next   = N_CLEAR_APPEND;
                            end
                        end
                        else
                        begin
                            state_next = S_APPEND;
                        end
                    end
                endcase
            end

            // Read data for offset i is already registered; the next offset
            // is addressed in the same cycle the byte leaves.
            S_EMIT:
            begin
                i_final = (i_plus1 == emit_n_reg);
                rd_off  = CW'(i_reg);
                if (!res_full)
                begin
                    res_push  = 1'b1;
                    res.data  = rd_data_reg;
                    res.last  = emit_last_reg && i_final;
                    if (i_final)
                    begin
                        unique case (emit_then_reg)
                            E_CLEAR:
                            begin
                                do_clear   = 1'b1;
                                state_next = S_IDLE;
                            end
                            E_NL:
                            begin
                                state_next = S_NL;
                            end
                            default:
                            begin
                                state_next = S_SHIFT;
                            end
                        endcase
                    end
                    else
                    begin
                        i_next = AW'(i_plus1);
                        rd_off = i_plus1;
                    end
                end
            end

            // Drop the bytes before the break point by moving the head.
            S_SHIFT:
            begin
                rd_off          = CW'(brk_reg);
                head_next       = rd_addr;
                fill_next       = fill_reg - CW'(brk_reg);
                col_next        = '0;
                rem_next        = '0;
                stale_next      = 1'b0;
                brk_next        = '0;
                prev_blank_next = 1'b1;
                i_next          = '0;
                state_next      = (fill_reg == CW'(brk_reg)) ? S_RECHECK : S_SCAN;
            end

            S_SCAN:
            begin
                i_final = (i_plus1 == fill_reg);
                rd_off  = i_plus1;
                if (rd_blank && !prev_blank_reg)
                begin
                    brk_next = i_reg;
                end
                col_next        = scan_step.col;
                rem_next        = scan_step.rem;
                prev_blank_next = rd_blank;
                if (i_final)
                begin
                    state_next = S_RECHECK;
                end
                else
                begin
                    i_next = AW'(i_plus1);
                end
            end

            S_RECHECK:
            begin
                second       = (fill_reg != '0) && cur_ovf;
                nl_last_next = !second;
                nl_then_next = second ? N_HARD : N_APPEND;
                state_next   = S_NL;
            end

            S_NL:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    res.data = CH_NEWLINE;
                    res.last = nl_last_reg;
                    unique case (nl_then_reg)
                        N_CLEAR_IDLE:
                        begin
                            do_clear   = 1'b1;
                            state_next = S_IDLE;
                        end
                        N_CLEAR_APPEND:
                        begin
                            do_clear   = 1'b1;
                            state_next = S_APPEND;
                        end
                        N_APPEND:
                        begin
                            state_next = S_APPEND;
                        end
                        default:
                        begin
                            i_next         = '0;
                            emit_n_next    = fill_reg;
                            emit_last_next = 1'b0;
                            emit_then_next = E_NL;
                            nl_last_next   = 1'b1;
                            nl_then_next   = N_CLEAR_APPEND;
                            state_next     = S_EMIT;
                        end
                    endcase
                end
            end

            S_APPEND:
            begin
                if (fill_reg < CW'(MAX_COLUMNS))
                begin
                    mem_we = 1'b1;
                    if (cmd_reg.is_blank && !prev_blank_reg)
                    begin
                        brk_next = AW'(fill_reg);
                    end
                    fill_next       = fill_reg + CW'(1);
                    // The column register keeps six bits; if that wraps, the
                    // tab phase has to be rebuilt before the next character.
                    col_next        = COLW'(cur_step.col[FOLD_W-1:0]);
                    rem_next        = cur_step.rem;
                    prev_blank_next = cmd_reg.is_blank;
                    if ((cur_step.col >> FOLD_W) != '0)
                    begin
                        stale_next = 1'b1;
                    end
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_clear)
        begin
            fill_next       = '0;
            col_next        = '0;
            rem_next        = '0;
            stale_next      = 1'b0;
            brk_next        = '0;
            prev_blank_next = 1'b1;
        end

        if (cfg_we && (cfg_index == CFG_TAB_WIDTH))
        begin
            stale_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[wr_addr] <= cmd_reg.ch;
        end
        rd_data_reg <= line_mem[rd_addr];
        cmd_reg     <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg <= FOLD_RESET;
            tab_reg  <= TAB_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FOLD_COLUMN: fold_reg <= cfg_wdata;
                CFG_TAB_WIDTH:   tab_reg  <= cfg_wdata[TAB_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            col_reg        <= '0;
            rem_reg        <= '0;
            stale_reg      <= 1'b0;
            brk_reg        <= '0;
            prev_blank_reg <= 1'b1;
            head_reg       <= '0;
            i_reg          <= '0;
            emit_n_reg     <= '0;
            emit_last_reg  <= 1'b0;
            emit_then_reg  <= E_CLEAR;
            nl_last_reg    <= 1'b0;
            nl_then_reg    <= N_CLEAR_IDLE;
            mod_bit_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            col_reg        <= col_next;
            rem_reg        <= rem_next;
            stale_reg      <= stale_next;
            brk_reg        <= brk_next;
            prev_blank_reg <= prev_blank_next;
            head_reg       <= head_next;
            i_reg          <= i_next;
            emit_n_reg     <= emit_n_next;
            emit_last_reg  <= emit_last_next;
            emit_then_reg  <= emit_then_next;
            nl_last_reg    <= nl_last_next;
            nl_then_reg    <= nl_then_next;
            mod_bit_reg    <= mod_bit_next;
        end
    end

endmodule

`default_nettype wire
